/* hw/rtl/fpfa_pkg.sv */
// Shared types and constants of the fixed partition fit allocator.
package fpfa_pkg;

    localparam int MAX_PARTITIONS = 16;
    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int SIZE_W = 16;
    localparam int LABEL_W = 16;
    localparam int TAG_W = 8;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_ARRANGE = 2'd2;
    localparam logic [1:0] CMD_ALLOCATE = 2'd3;

    localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT = 2'd1;
    localparam logic [1:0] STATUS_DONE = 2'd2;
    localparam logic [1:0] STATUS_FULL = 2'd3;

    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [SIZE_W-1:0]  size_kb;
        logic [LABEL_W-1:0] part_label;
        logic [TAG_W-1:0]   request_tag;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [LABEL_W-1:0] granted_label;
        logic [TAG_W-1:0]   tag_out;
    } rsp_item_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [SIZE_W-1:0]  room;
        logic [LABEL_W-1:0] label;
    } tbl_write_t;

endpackage

/* hw/rtl/fpfa_table.sv */
// Partition table with one write port and one read port.
module fpfa_table (
    input  logic                       clk,
    input  fpfa_pkg::tbl_write_t       wr,
    input  logic [fpfa_pkg::IDX_W-1:0] raddr,
    output logic [fpfa_pkg::SIZE_W-1:0]  rd_room,
    output logic [fpfa_pkg::LABEL_W-1:0] rd_label
);
    import fpfa_pkg::*;

    logic [SIZE_W-1:0]  room_reg [MAX_PARTITIONS];
    logic [LABEL_W-1:0] label_reg [MAX_PARTITIONS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            room_reg[wr.addr]  <= wr.room;
            label_reg[wr.addr] <= wr.label;
        end
    end

    assign rd_room  = room_reg[raddr];
    assign rd_label = label_reg[raddr];

endmodule

/* hw/rtl/fpfa_alu.sv */
// Shared compare and subtract unit for room values.
module fpfa_alu (
    input  logic [fpfa_pkg::SIZE_W-1:0] a,
    input  logic [fpfa_pkg::SIZE_W-1:0] b,
    output logic                        lt,
    output logic                        gt,
    output logic [fpfa_pkg::SIZE_W-1:0] diff
);
    import fpfa_pkg::*;

    logic [SIZE_W:0] sub;

    assign sub  = {1'b0, a} - {1'b0, b};
    assign lt   = sub[SIZE_W];
    assign gt   = !sub[SIZE_W] && (sub[SIZE_W-1:0] != '0);
    assign diff = sub[SIZE_W-1:0];

endmodule

/* hw/rtl/fixed_partition_fit_allocator_unit.sv */
// Top level of the fixed partition fit allocator: sequencer and result register.
//
// Each item returns exactly one result item. Clear and load go straight
// from acceptance to the done state, which writes the result to the output
// register. Allocate scans the table one entry per cycle through the shared
// compare unit. Arrange under best or worst fit runs the exchange sort on
// the single table read port, one comparison per cycle within each pass;
// under any other policy it leaves the table as it is. The block takes a
// new item only while its sequencer is idle, and it may do so while the
// previous result still waits in the output register.
module fixed_partition_fit_allocator_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  fpfa_pkg::req_item_t   req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output fpfa_pkg::rsp_item_t   rsp,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_wdata
);
    import fpfa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SORT_LOAD,
        ST_SORT_CMP,
        ST_SORT_STORE,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         policy_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   y_reg, y_next;
    logic [CNT_W-1:0]   z_reg, z_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [1:0]         status_reg, status_next;
    logic [LABEL_W-1:0] grant_reg, grant_next;
    logic [SIZE_W-1:0]  cy_room_reg, cy_room_next;
    logic [LABEL_W-1:0] cy_label_reg, cy_label_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_reg, rsp_next;

    tbl_write_t         wr;
    logic [IDX_W-1:0]   raddr;
    logic [SIZE_W-1:0]  rd_room;
    logic [LABEL_W-1:0] rd_label;
    logic [SIZE_W-1:0]  alu_a, alu_b, alu_diff;
    logic               alu_lt, alu_gt;
    logic               do_swap;

    fpfa_table u_table (
        .clk      (clk),
        .wr       (wr),
        .raddr    (raddr),
        .rd_room  (rd_room),
        .rd_label (rd_label)
    );

    fpfa_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .lt   (alu_lt),
        .gt   (alu_gt),
        .diff (alu_diff)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        case (state_reg)
            ST_SCAN:      raddr = k_reg[IDX_W-1:0];
            ST_SORT_LOAD: raddr = y_reg[IDX_W-1:0];
            default:      raddr = z_reg[IDX_W-1:0];
        endcase
        if (state_reg == ST_SCAN)
        begin
            alu_a = rd_room;
            alu_b = size_reg;
        end
        else
        begin
            alu_a = cy_room_reg;
            alu_b = rd_room;
        end
        do_swap = (policy_reg == POLICY_BEST) ? alu_gt : alu_lt;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        size_next      = size_reg;
        tag_next       = tag_reg;
        status_next    = status_reg;
        grant_next     = grant_reg;
        cy_room_next   = cy_room_reg;
        cy_label_next  = cy_label_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    size_next   = req.size_kb;
                    tag_next    = req.request_tag;
                    status_next = STATUS_DONE;
                    grant_next  = '0;
                    state_next  = ST_DONE;
                    case (req.cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (count_reg >= CNT_W'(MAX_PARTITIONS))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                wr.en      = 1'b1;
                                wr.addr    = count_reg[IDX_W-1:0];
                                wr.room    = req.size_kb;
                                wr.label   = req.part_label;
                                count_next = CNT_W'(count_reg + 1'b1);
                            end
                        end
                        CMD_ARRANGE:
                        begin
                            if ((policy_reg == POLICY_BEST || policy_reg == POLICY_WORST)
                                && count_reg != '0)
                            begin
                                y_next     = '0;
                                state_next = ST_SORT_LOAD;
                            end
                        end
                        CMD_ALLOCATE:
                        begin
                            k_next     = '0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (k_reg == count_reg)
                begin
                    status_next = STATUS_NO_FIT;
                    state_next  = ST_DONE;
                end
                else if (!alu_lt)
                begin
                    wr.en       = 1'b1;
                    wr.addr     = k_reg[IDX_W-1:0];
                    wr.room     = alu_diff;
                    wr.label    = rd_label;
                    status_next = STATUS_ALLOCATED;
                    grant_next  = rd_label;
                    state_next  = ST_DONE;
                end
                else
                begin
                    k_next = CNT_W'(k_reg + 1'b1);
                end
            end
            ST_SORT_LOAD:
            begin
                cy_room_next  = rd_room;
                cy_label_next = rd_label;
                z_next        = y_reg;
                state_next    = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                if (do_swap)
                begin
                    wr.en         = 1'b1;
                    wr.addr       = z_reg[IDX_W-1:0];
                    wr.room       = cy_room_reg;
                    wr.label      = cy_label_reg;
                    cy_room_next  = rd_room;
                    cy_label_next = rd_label;
                end
                if (CNT_W'(z_reg + 1'b1) == count_reg)
                begin
                    state_next = ST_SORT_STORE;
                end
                else
                begin
                    z_next = CNT_W'(z_reg + 1'b1);
                end
            end
            ST_SORT_STORE:
            begin
                wr.en    = 1'b1;
                wr.addr  = y_reg[IDX_W-1:0];
                wr.room  = cy_room_reg;
                wr.label = cy_label_reg;
                if (CNT_W'(y_reg + 1'b1) == count_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    y_next     = CNT_W'(y_reg + 1'b1);
                    state_next = ST_SORT_LOAD;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.status        = status_reg;
                    rsp_next.granted_label = grant_reg;
                    rsp_next.tag_out       = tag_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            policy_reg    <= POLICY_FIRST;
            count_reg     <= '0;
            k_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            size_reg      <= '0;
            tag_reg       <= '0;
            status_reg    <= STATUS_DONE;
            grant_reg     <= '0;
            cy_room_reg   <= '0;
            cy_label_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            k_reg         <= k_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            size_reg      <= size_next;
            tag_reg       <= tag_next;
            status_reg    <= status_next;
            grant_reg     <= grant_next;
            cy_room_reg   <= cy_room_next;
            cy_label_reg  <= cy_label_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the fixed partition fit allocator unit.
module tb;

    import fpfa_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;
    logic      cfg_we;
    logic [1:0] cfg_wdata;

    logic [SIZE_W-1:0]  room_left [MAX_PARTITIONS];
    logic [LABEL_W-1:0] slot_label [MAX_PARTITIONS];
    int unsigned        slot_count;
    logic [1:0]         fit_policy_cfg;

    rsp_item_t pending_results[$];
    int        errors = 0;
    int        cycle_cnt = 0;
    int        stall_left = 0;
    int        hold_left = 0;
    bit        send_idle_on = 1'b1;
    bit        rsp_idle_on = 1'b1;

    fixed_partition_fit_allocator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The long receiver hold-off counts down here, one clock at a time.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
                hold_left = hold_left - 1;
        end
    end

    function automatic rsp_item_t predict_fit(req_item_t r);
        rsp_item_t          res;
        logic [SIZE_W-1:0]  t_room;
        logic [LABEL_W-1:0] t_label;
        bit                 swap_it;
        res.status = STATUS_DONE;
        res.granted_label = '0;
        res.tag_out = r.request_tag;
        case (r.cmd)
            CMD_CLEAR:
                slot_count = 0;
            CMD_LOAD:
                if (slot_count >= MAX_PARTITIONS)
                    res.status = STATUS_FULL;
                else
                begin
                    room_left[slot_count] = r.size_kb;
                    slot_label[slot_count] = r.part_label;
                    slot_count = slot_count + 1;
                end
            CMD_ARRANGE:
                if (fit_policy_cfg == POLICY_BEST || fit_policy_cfg == POLICY_WORST)
                begin
                    for (int y = 0; y < slot_count; y++)
                    begin
                        for (int z = y; z < slot_count; z++)
                        begin
                            if (fit_policy_cfg == POLICY_BEST)
                                swap_it = room_left[y] > room_left[z];
                            else
                                swap_it = room_left[y] < room_left[z];
                            if (swap_it)
                            begin
                                t_room = room_left[y];
                                room_left[y] = room_left[z];
                                room_left[z] = t_room;
                                t_label = slot_label[y];
                                slot_label[y] = slot_label[z];
                                slot_label[z] = t_label;
                            end
                        end
                    end
                end
            default:
            begin
                res.status = STATUS_NO_FIT;
                for (int k = 0; k < slot_count && res.status == STATUS_NO_FIT; k++)
                begin
                    if (r.size_kb <= room_left[k])
                    begin
                        room_left[k] = room_left[k] - r.size_kb;
                        res.granted_label = slot_label[k];
                        res.status = STATUS_ALLOCATED;
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic req_item_t make_item(logic [1:0] cmd, logic [SIZE_W-1:0] size,
                                            logic [LABEL_W-1:0] label, logic [TAG_W-1:0] tag);
        req_item_t it;
        it.cmd = cmd;
        it.size_kb = size;
        it.part_label = label;
        it.request_tag = tag;
        return it;
    endfunction

    function automatic logic [SIZE_W-1:0] rand_room();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] rand_request();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(1, 600));
        endcase
    endfunction

    task automatic send_item(req_item_t it);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        do
            @(posedge clk);
        while (req_stall);
        pending_results.push_back(predict_fit(it));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_policy(logic [1:0] p);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= p;
        @(negedge clk);
        cfg_we <= 1'b0;
        fit_policy_cfg = p;
    endtask

    // Mostly well-formed table sessions with random content, plus random noise items.
    task automatic run_workload(int n_items);
        int issued = 0;
        int n_load;
        int n_alloc;
        while (issued < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                send_item(make_item(CMD_CLEAR, SIZE_W'($urandom), LABEL_W'($urandom),
                                    TAG_W'($urandom)));
                n_load = ($urandom_range(0, 7) == 0) ? MAX_PARTITIONS + 2
                                                     : $urandom_range(1, MAX_PARTITIONS);
                for (int i = 0; i < n_load; i++)
                    send_item(make_item(CMD_LOAD, rand_room(), LABEL_W'($urandom),
                                        TAG_W'($urandom)));
                if ($urandom_range(0, 3) != 0)
                    send_item(make_item(CMD_ARRANGE, SIZE_W'($urandom), LABEL_W'($urandom),
                                        TAG_W'($urandom)));
                n_alloc = $urandom_range(1, 8);
                for (int i = 0; i < n_alloc; i++)
                    send_item(make_item(CMD_ALLOCATE, rand_request(), LABEL_W'($urandom),
                                        TAG_W'($urandom)));
                issued += 2 + n_load + n_alloc;
            end
            else
            begin
                send_item(make_item(2'($urandom_range(0, 3)), SIZE_W'($urandom),
                                    LABEL_W'($urandom), TAG_W'($urandom)));
                issued++;
            end
        end
    endtask

    task automatic test_directed_corners();
        set_policy(POLICY_FIRST);
        send_item(make_item(CMD_ALLOCATE, '0, '1, 8'h00));
        send_item(make_item(CMD_ARRANGE, '1, '0, 8'hFF));
        for (int i = 0; i < MAX_PARTITIONS; i++)
        begin
            if (i == 0)
                send_item(make_item(CMD_LOAD, '0, '0, 8'h00));
            else if (i == 1)
                send_item(make_item(CMD_LOAD, '1, '1, 8'hFF));
            else
                send_item(make_item(CMD_LOAD, SIZE_W'(100 * i), LABEL_W'(i), TAG_W'(i)));
        end
        send_item(make_item(CMD_LOAD, 16'h1234, 16'hBEEF, 8'hA5));
        send_item(make_item(CMD_ALLOCATE, '0, '0, 8'h5A));
        send_item(make_item(CMD_ALLOCATE, '1, '0, 8'hFF));
        send_item(make_item(CMD_ALLOCATE, '1, '1, 8'h01));
        send_item(make_item(CMD_ARRANGE, '0, '0, 8'h02));
        send_item(make_item(CMD_ALLOCATE, 16'd250, '0, 8'h03));
        send_item(make_item(CMD_CLEAR, '1, '1, 8'hFF));
    endtask

    task automatic test_policy_sweep();
        set_policy(POLICY_BEST);
        send_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        run_workload(150);
        set_policy(POLICY_WORST);
        send_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        run_workload(150);
        set_policy(2'd3);
        send_idle_on = 1'b1;
        rsp_idle_on = 1'b0;
        run_workload(150);
        set_policy(POLICY_FIRST);
        send_idle_on = 1'b0;
        rsp_idle_on = 1'b1;
        run_workload(150);
    endtask

    task automatic test_output_backpressure();
        set_policy(POLICY_BEST);
        send_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        @(negedge clk);
        hold_left = 300;
        run_workload(60);
        send_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        set_policy(POLICY_WORST);
        for (int i = 0; i < 4; i++)
        begin
            run_workload(15);
            wait_drained();
        end
    endtask

    // Result checking and receiver stalls share one loop.
    initial
    begin
        rsp_item_t exp_rsp;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: status %0d, label %0d, tag %0d",
                           rsp.status, rsp.granted_label, rsp.tag_out);
                    errors++;
                end
                else
                begin
                    exp_rsp = pending_results.pop_front();
                    if (rsp.status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_rsp.status, rsp.status);
                        errors++;
                    end
                    if (rsp.granted_label !== exp_rsp.granted_label)
                    begin
                        $error("granted_label: expected %0d, actual %0d",
                               exp_rsp.granted_label, rsp.granted_label);
                        errors++;
                    end
                    if (rsp.tag_out !== exp_rsp.tag_out)
                    begin
                        $error("tag_out: expected %0d, actual %0d", exp_rsp.tag_out, rsp.tag_out);
                        errors++;
                    end
                end
                stall_left = rsp_idle_on ? $urandom_range(0, 14) : 0;
            end
            @(negedge clk);
            rsp_stall <= (hold_left > 0 || stall_left > 0);
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        fit_policy_cfg = POLICY_FIRST;
        slot_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_policy_sweep();
        test_output_backpressure();
        test_drain_pause();

        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
